// ===== hdl/pspp_pkg.sv =====
// shared types and constants of the program stream pes parser
package pspp_pkg;

   localparam int unsigned POS_W  = 48;
   localparam int unsigned ADDR_W = 3;

   localparam logic REG_MAX_PAYLOAD = 1'b0;
   localparam logic REG_KEEP_PCM    = 1'b1;

   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   localparam logic [7:0] ID_PACK    = 8'hBA;
   localparam logic [7:0] ID_SYSTEM  = 8'hBB;
   localparam logic [7:0] ID_PRIV1   = 8'hBD;
   localparam logic [7:0] ID_PADDING = 8'hBE;
   localparam logic [7:0] ID_PRIV2   = 8'hBF;
   localparam logic [7:0] SUB_NONE   = 8'hFF;

   typedef enum logic [19:0] {
      PH_SEARCH      = 20'h00001,
      PH_SKIP_RESYNC = 20'h00002,
      PH_SKLEN_HI    = 20'h00004,
      PH_SKLEN_LO    = 20'h00008,
      PH_LEN_HI      = 20'h00010,
      PH_LEN_LO      = 20'h00020,
      PH_PS2_SUB     = 20'h00040,
      PH_STUFF       = 20'h00080,
      PH_STD1        = 20'h00100,
      PH_STD2        = 20'h00200,
      PH_M1_PTS      = 20'h00400,
      PH_M1_DTS      = 20'h00800,
      PH_M2_FLAGS    = 20'h01000,
      PH_M2_HLEN     = 20'h02000,
      PH_M2_PTS      = 20'h04000,
      PH_M2_DTS      = 20'h08000,
      PH_SKIP_HDR    = 20'h10000,
      PH_SUBID       = 20'h20000,
      PH_SKIP_AUDIO  = 20'h40000,
      PH_PAYLOAD     = 20'h80000
   } phase_type;

   typedef struct packed {
      logic [15:0] max_payload;
      logic        keep_pcm_header;
   } cfg_type;

   typedef struct packed {
      logic             kind;
      logic [7:0]       stream_id;
      logic [15:0]      payload_len;
      logic [31:0]      pts;
      logic             pts_valid;
      logic [31:0]      dts;
      logic             dts_valid;
      logic [POS_W-1:0] packet_pos;
      logic [7:0]       data;
      logic             last;
   } rsp_type;

   function automatic logic [31:0] ts_bits(input logic [2:0] idx, input logic [7:0] b);
      logic [31:0] r;
      r = '0;
      unique case (idx)
         3'd0: r[31:30] = b[2:1];
         3'd1: r[29:22] = b;
         3'd2: r[21:15] = b[7:1];
         3'd3: r[14:7]  = b;
         default: r[6:0] = b[7:1];
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/pspp_req_if.sv =====
// input byte channel
interface pspp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

// ===== hdl/pspp_rsp_if.sv =====
// result channel
interface pspp_rsp_if import pspp_pkg::*;;
   logic             valid;
   logic             ready;
   logic             kind;
   logic [7:0]       stream_id;
   logic [15:0]      payload_len;
   logic [31:0]      pts;
   logic             pts_valid;
   logic [31:0]      dts;
   logic             dts_valid;
   logic [POS_W-1:0] packet_pos;
   logic [7:0]       data;
   logic             last;
   modport source (output valid, output kind, output stream_id, output payload_len,
                   output pts, output pts_valid, output dts, output dts_valid,
                   output packet_pos, output data, output last, input ready);
   modport sink (input valid, input kind, input stream_id, input payload_len,
                 input pts, input pts_valid, input dts, input dts_valid,
                 input packet_pos, input data, input last, output ready);
endinterface

// ===== hdl/pspp_csr.sv =====
// configuration registers behind the apb port
module pspp_csr import pspp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output cfg_type           cfg
);
   logic [15:0] max_ff;
   logic        keep_ff;
   logic        wr;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= 16'hFFFF;
         keep_ff <= 1'b0;
      end else if (wr) begin
         unique case (paddr[2])
            REG_MAX_PAYLOAD: max_ff <= pwdata[15:0];
            default: keep_ff <= pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_MAX_PAYLOAD: prdata = {16'd0, max_ff};
         default: prdata = {31'd0, keep_ff};
      endcase
   end

   assign cfg.max_payload     = max_ff;
   assign cfg.keep_pcm_header = keep_ff;
endmodule

// ===== hdl/pspp_core.sv =====
// header state machine: one byte in, at most one result out
module pspp_core import pspp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       take,
   input  logic [7:0] b,
   output logic       res_valid,
   output rsp_type    res
);
   phase_type        phase_ff, phase_in;
   logic [23:0]      win_ff, win_in;
   logic [POS_W-1:0] pos_ff, pos_in, spos_ff, spos_in;
   logic [15:0]      rem_ff, rem_in, skip_ff, skip_in;
   logic [7:0]       hl_ff, hl_in, flag_ff, flag_in, strm_ff, strm_in, sub_ff, sub_in;
   logic [31:0]      pts_ff, pts_in, dts_ff, dts_in;
   logic [1:0]       tsf_ff, tsf_in;
   logic [2:0]       fi_ff, fi_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         win_ff   <= 24'hFFFFFF;
         pos_ff   <= '0;
         spos_ff  <= '0;
         rem_ff   <= '0;
         skip_ff  <= '0;
         hl_ff    <= '0;
         flag_ff  <= '0;
         strm_ff  <= '0;
         sub_ff   <= SUB_NONE;
         pts_ff   <= '0;
         dts_ff   <= '0;
         tsf_ff   <= '0;
         fi_ff    <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         win_ff   <= win_in;
         pos_ff   <= pos_in;
         spos_ff  <= spos_in;
         rem_ff   <= rem_in;
         skip_ff  <= skip_in;
         hl_ff    <= hl_in;
         flag_ff  <= flag_in;
         strm_ff  <= strm_in;
         sub_ff   <= sub_in;
         pts_ff   <= pts_in;
         dts_ff   <= dts_in;
         tsf_ff   <= tsf_in;
         fi_ff    <= fi_in;
      end
   end

   always_comb begin
      logic do_class, allow_std, do_after, do_pcheck, do_finish, rsync;
      logic [7:0] outid;
      logic [15:0] strip;
      phase_in = phase_ff;
      win_in = win_ff;
      pos_in = pos_ff + 1'b1;
      spos_in = spos_ff;
      rem_in = rem_ff;
      skip_in = skip_ff;
      hl_in = hl_ff;
      flag_in = flag_ff;
      strm_in = strm_ff;
      sub_in = sub_ff;
      pts_in = pts_ff;
      dts_in = dts_ff;
      tsf_in = tsf_ff;
      fi_in = fi_ff;
      do_class = 1'b0;
      allow_std = 1'b0;
      do_after = 1'b0;
      do_pcheck = 1'b0;
      do_finish = 1'b0;
      rsync = 1'b0;
      strip = '0;
      res_valid = 1'b0;
      res = '0;

      unique case (phase_ff)
         PH_SKIP_RESYNC, PH_SKIP_HDR, PH_SKIP_AUDIO: begin
            skip_in = (skip_ff != 16'd0) ? skip_ff - 16'd1 : 16'd0;
            if (skip_in == 16'd0) begin
               if (phase_ff == PH_SKIP_RESYNC) rsync = 1'b1;
               else if (phase_ff == PH_SKIP_HDR) do_pcheck = 1'b1;
               else do_finish = 1'b1;
            end
         end
         PH_SKLEN_HI: begin
            skip_in = {b, 8'd0};
            phase_in = PH_SKLEN_LO;
         end
         PH_SKLEN_LO: begin
            skip_in = skip_ff | {8'd0, b};
            if (skip_in == 16'd0) rsync = 1'b1;
            else phase_in = PH_SKIP_RESYNC;
         end
         PH_LEN_HI: begin
            rem_in = {b, 8'd0};
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            rem_in = rem_ff | {8'd0, b};
            if (rem_in == 16'd0) rsync = 1'b1;
            else phase_in = (strm_ff == ID_PRIV2) ? PH_PS2_SUB : PH_STUFF;
         end
         PH_PS2_SUB: begin
            sub_in = b + 8'h60;
            rem_in = rem_ff - 16'd1;
            do_finish = 1'b1;
         end
         PH_STUFF: begin
            rem_in = rem_ff - 16'd1;
            if (b == 8'hFF) begin
               if (rem_in == 16'd0) rsync = 1'b1;
            end else begin
               do_class = 1'b1;
               allow_std = 1'b1;
            end
         end
         PH_STD1: phase_in = PH_STD2;
         PH_STD2: do_class = 1'b1;
         PH_M1_PTS, PH_M2_PTS: begin
            pts_in = ((fi_ff == 3'd0) ? 32'd0 : pts_ff) | ts_bits(fi_ff, b);
            fi_in = fi_ff + 3'd1;
            if (fi_in >= 3'd5) begin
               dts_in = pts_in;
               tsf_in = 2'd1;
               fi_in = 3'd0;
               if (phase_ff == PH_M1_PTS) begin
                  if (flag_ff[4]) begin
                     if (rem_ff <= 16'd5) rsync = 1'b1;
                     else begin
                        rem_in = rem_ff - 16'd5;
                        phase_in = PH_M1_DTS;
                     end
                  end else do_pcheck = 1'b1;
               end else begin
                  if (flag_ff[6]) begin
                     if (hl_ff < 8'd5 || rem_ff <= {8'd0, hl_ff}) rsync = 1'b1;
                     else begin
                        hl_in = hl_ff - 8'd5;
                        rem_in = rem_ff - 16'd5;
                        phase_in = PH_M2_DTS;
                     end
                  end else do_after = 1'b1;
               end
            end
         end
         PH_M1_DTS, PH_M2_DTS: begin
            dts_in = ((fi_ff == 3'd0) ? 32'd0 : dts_ff) | ts_bits(fi_ff, b);
            fi_in = fi_ff + 3'd1;
            if (fi_in >= 3'd5) begin
               tsf_in = tsf_ff | 2'd2;
               fi_in = 3'd0;
               if (phase_ff == PH_M1_DTS) do_pcheck = 1'b1;
               else do_after = 1'b1;
            end
         end
         PH_M2_FLAGS: begin
            flag_in = b;
            phase_in = PH_M2_HLEN;
         end
         PH_M2_HLEN: begin
            hl_in = b;
            if (rem_ff <= {8'd0, b}) rsync = 1'b1;
            else if (flag_ff[7]) begin
               if (b < 8'd5) rsync = 1'b1;
               else begin
                  hl_in = b - 8'd5;
                  rem_in = rem_ff - 16'd5;
                  fi_in = 3'd0;
                  phase_in = PH_M2_PTS;
               end
            end else do_after = 1'b1;
         end
         PH_SUBID: begin
            rem_in = rem_ff - 16'd1;
            strip = 16'd3;
            sub_in = b;
            if (b >= 8'h88 && b <= 8'h8B) sub_in = b - 8'h48;
            else if (b >= 8'h80 && b <= 8'h87) sub_in = b - 8'h80;
            else if (b >= 8'hA0 && b <= 8'hA7) strip = cfg.keep_pcm_header ? 16'd3 : 16'd6;
            else if (b >= 8'h20 && b <= 8'h27) strip = 16'd0;
            else sub_in = SUB_NONE;
            if (strip != 16'd0) begin
               if (rem_in <= strip) rsync = 1'b1;
               else begin
                  rem_in = rem_in - strip;
                  skip_in = strip;
                  phase_in = PH_SKIP_AUDIO;
               end
            end else do_finish = 1'b1;
         end
         PH_PAYLOAD: begin
            rem_in = (rem_ff != 16'd0) ? rem_ff - 16'd1 : 16'd0;
            res_valid = 1'b1;
            res.kind = KIND_PAYLOAD;
            res.stream_id = (strm_ff == ID_PRIV1 || strm_ff == ID_PRIV2) ? sub_ff : strm_ff;
            res.packet_pos = spos_ff;
            res.data = b;
            res.last = (rem_in == 16'd0);
            if (rem_in == 16'd0) rsync = 1'b1;
         end
         default: begin
            if (win_ff == 24'd1) begin
               spos_in = pos_ff - 3'd3;
               win_in = 24'hFFFFFF;
               strm_in = b;
               sub_in = SUB_NONE;
               tsf_in = '0;
               pts_in = '0;
               dts_in = '0;
               if (b == ID_PACK) begin
                  skip_in = 16'd8;
                  phase_in = PH_SKIP_RESYNC;
               end else if (b == ID_PADDING || b == ID_SYSTEM) begin
                  phase_in = PH_SKLEN_HI;
               end else if ((b >= 8'hC0 && b <= 8'hEF) || (b >= 8'h20 && b <= 8'h29) ||
                            b == ID_PRIV1 || b == ID_PRIV2) begin
                  phase_in = PH_LEN_HI;
               end else begin
                  phase_in = PH_SEARCH;
               end
            end else begin
               win_in = {win_ff[15:0], b};
               phase_in = PH_SEARCH;
            end
         end
      endcase

      if (do_class) begin
         if (allow_std && b[7:6] == 2'b01) begin
            if (rem_in <= 16'd2) rsync = 1'b1;
            else begin
               rem_in = rem_in - 16'd2;
               phase_in = PH_STD1;
            end
         end else if (b[7:5] == 3'b001) begin
            if (rem_in <= 16'd4) rsync = 1'b1;
            else begin
               rem_in = rem_in - 16'd4;
               pts_in = ts_bits(3'd0, b);
               flag_in = b;
               fi_in = 3'd1;
               phase_in = PH_M1_PTS;
            end
         end else if (b[7:6] == 2'b10) begin
            if (rem_in <= 16'd2) rsync = 1'b1;
            else begin
               rem_in = rem_in - 16'd2;
               phase_in = PH_M2_FLAGS;
            end
         end else if (b != 8'h0F) rsync = 1'b1;
         else do_pcheck = 1'b1;
      end

      if (do_after) begin
         if (hl_in != 8'd0) begin
            if (rem_in <= {8'd0, hl_in}) rsync = 1'b1;
            else begin
               rem_in = rem_in - {8'd0, hl_in};
               skip_in = {8'd0, hl_in};
               phase_in = PH_SKIP_HDR;
            end
         end else do_pcheck = 1'b1;
      end

      if (do_pcheck) begin
         if (strm_in == ID_PRIV1) begin
            if (rem_in == 16'd0) rsync = 1'b1;
            else phase_in = PH_SUBID;
         end else do_finish = 1'b1;
      end

      outid = (strm_in == ID_PRIV1 || strm_in == ID_PRIV2) ? sub_in : strm_in;
      if (do_finish) begin
         if (rem_in == 16'd0 || rem_in > cfg.max_payload) rsync = 1'b1;
         else begin
            res_valid = 1'b1;
            res.kind = KIND_HEADER;
            res.stream_id = outid;
            res.payload_len = rem_in;
            res.pts = tsf_in[0] ? pts_in : 32'd0;
            res.pts_valid = tsf_in[0];
            res.dts = (tsf_in != 2'd0) ? dts_in : 32'd0;
            res.dts_valid = (tsf_in != 2'd0);
            res.packet_pos = spos_ff;
            phase_in = PH_PAYLOAD;
         end
      end

      if (rsync) begin
         phase_in = PH_SEARCH;
         win_in = 24'hFFFFFF;
      end
   end
endmodule

// ===== hdl/pspp_out.sv =====
// result register between the parser and the result channel
module pspp_out import pspp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type din,
   input  logic    out_ready,
   output logic    room,
   output logic    out_valid,
   output rsp_type dout
);
   logic    vld_ff, vld_in;
   rsp_type data_ff;

   assign room   = !vld_ff || out_ready;
   assign vld_in = load ? 1'b1 : (vld_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= din;
   end

   assign out_valid = vld_ff;
   assign dout      = data_ff;
endmodule

// ===== hdl/program_stream_pes_parser.sv =====
// top level of the program stream pes parser
//
// req_chan carries one program stream byte per item; rsp_chan returns a header
// item (kind 0) for each accepted pes packet, then one item per payload byte
// with last set on the final one. csr port: register 0 at address 0 is the
// largest payload accepted, register 1 at address 4 keeps the pcm header.
// a byte is taken at its accepting edge: the header state machine updates on the
// accepting edge and any result lands in the output register at that edge,
// so a result is visible in the cycle after its byte, and one byte per cycle is
// sustained while rsp_chan takes items.
// if rsp_chan stalls with a result held, req_chan.ready drops until the held
// result is taken; bytes that make no result still need a free output slot.
// reset clears the state machine to start code search, the byte counter to
// zero and the registers to 65535 and 0, and empties the output register.
module program_stream_pes_parser import pspp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   pspp_req_if.sink          req_chan,
   pspp_rsp_if.source        rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   cfg_type cfg;
   rsp_type res, held;
   logic    res_valid, room, take;

   pspp_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
   );

   assign req_chan.ready = room;
   assign take = req_chan.valid && room;

   pspp_core u_core (
      .clock, .reset, .cfg, .take, .b(req_chan.data_byte), .res_valid, .res
   );

   pspp_out u_out (
      .clock, .reset, .load(take && res_valid), .din(res), .out_ready(rsp_chan.ready),
      .room, .out_valid(rsp_chan.valid), .dout(held)
   );

   assign rsp_chan.kind        = held.kind;
   assign rsp_chan.stream_id   = held.stream_id;
   assign rsp_chan.payload_len = held.payload_len;
   assign rsp_chan.pts         = held.pts;
   assign rsp_chan.pts_valid   = held.pts_valid;
   assign rsp_chan.dts         = held.dts;
   assign rsp_chan.dts_valid   = held.dts_valid;
   assign rsp_chan.packet_pos  = held.packet_pos;
   assign rsp_chan.data        = held.data;
   assign rsp_chan.last        = held.last;
endmodule
